// ----- rtl/tmtw_pkg.sv -----
// ----------------------------------------------------------------------------
// tmtw_pkg
// Shared types and constants of the text-mode terminal writer: command and
// response beats, configuration registers, opcodes and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tmtw_pkg;

    // Width of one screen cell: attribute in the high byte, character in the low byte.
    localparam int CELL_W = 16;

    // Operation codes carried by a command beat.
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Control characters handled by a put, and the space used for blanks.
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    // Reset values.
    localparam logic [7:0]        RESET_COLOR = 8'd7;
    localparam logic [3:0]        RESET_TAB   = 4'd4;
    localparam logic [CELL_W-1:0] RESET_CELL  = 16'h0720;

    // Configuration register indexes.
    localparam int               CFG_IDX_W      = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH  = 2'd1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  char_code;
        logic [10:0] read_index;
    } cmd_item_t;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_pos;
        logic [15:0] cell_data;
    } rsp_item_t;

    typedef struct packed {
        logic [7:0] text_color;
        logic [3:0] tab_width;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_TAB,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/text_mode_terminal_writer_core.sv -----
// ----------------------------------------------------------------------------
// text_mode_terminal_writer_core
// Character-cell text terminal with a ROWS by COLUMNS screen memory, a cursor,
// a configuration write port and a registered response stage.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all ROWS*COLUMNS cells
// that fills the screen with light grey blanks; command beats stall until
// it ends, while configuration writes are taken at once. The screen
// memory has one write port and one read port with a registered read, and
// its single write port sets the timing. A put of an ordinary character, a
// backspace, a newline that does not scroll and an unused opcode finish
// straight from idle, a read goes through a read state first, and a tab
// writes its spaces from a tab state. Any step that runs past the last row
// scrolls the screen: every row moves up one and the last row is blanked,
// one cell moved or blanked per cycle. A clear blanks every cell. Every command
// beat yields exactly one response beat with the cursor after the step; a
// finished response waits in the output register while the next command is accepted.
`default_nettype none

module text_mode_terminal_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_stall,
    input  wire tmtw_pkg::cmd_item_t             cmd,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output tmtw_pkg::rsp_item_t                  rsp,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tmtw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [7:0]                      cfg_data
);
    import tmtw_pkg::*;

    logic [7:0] text_color_reg;
    logic [3:0] tab_width_reg;
    cfg_t       cfg;

    logic       res_valid;
    rsp_item_t  res;
    logic       res_ready;

    logic       rsp_valid_reg;
    rsp_item_t  rsp_reg;

    // Registers are always writable; software is to write them only while idle (not enforced).
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
            tab_width_reg  <= RESET_TAB;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TEXT_COLOR: text_color_reg <= cfg_data;
                CFG_TAB_WIDTH:  tab_width_reg  <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    assign cfg.text_color = text_color_reg;
    assign cfg.tab_width  = tab_width_reg;

    tmtw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_stall (cmd_stall),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // The response register takes a new beat whenever it is empty or its
    // current beat leaves in this cycle; otherwise the engine holds its result.
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- rtl/tmtw_engine.sv -----
// ----------------------------------------------------------------------------
// tmtw_engine
// Screen memory, cursor and the sequencer that reads, modifies and writes
// the screen cells for put, clear, read, scroll and the reset clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tmtw_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire tmtw_pkg::cmd_item_t cmd,
    output logic                    cmd_stall,
    input  wire tmtw_pkg::cfg_t     cfg,
    output logic                    res_valid,
    output tmtw_pkg::rsp_item_t     res,
    input  wire logic               res_ready
);
    import tmtw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int COPY_N = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int LEFT_W = (COL_W + 1 > 4) ? COL_W + 1 : 4;

    state_t              state_reg, state_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [3:0]          tab_left_reg, tab_left_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic                copy_wr_reg, copy_wr_next;
    logic [ADDR_W-1:0]   copy_addr_reg, copy_addr_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [CELL_W-1:0]   data_hold_reg, data_hold_next;

    logic [CELL_W-1:0]   mem [CELLS];
    logic [CELL_W-1:0]   rd_data_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;

    logic [ADDR_W-1:0]   row_base;
    logic [ADDR_W-1:0]   cur_addr;
    logic [COL_W-1:0]    bs_col;
    logic [ADDR_W-1:0]   bs_addr;
    logic [LEFT_W-1:0]   cols_left;
    logic [3:0]          tab_n;
    logic                last_col;
    logic                last_row;
    logic                idx_ok;
    logic [CELL_W-1:0]   fill_word;
    logic [ADDR_W-1:0]   res_pos;
    logic [CELL_W-1:0]   res_data;

    logic                fin;
    logic                nl;
    logic                plain_go;
    logic                plain_more;
    logic [7:0]          plain_char;

    assign row_base  = ADDR_W'(row_reg) * ADDR_W'(COLUMNS);
    assign cur_addr  = row_base + ADDR_W'(col_reg);
    assign bs_col    = (col_reg == '0) ? '0 : col_reg - COL_W'(1);
    assign bs_addr   = row_base + ADDR_W'(bs_col);
    assign cols_left = LEFT_W'(COLUMNS) - LEFT_W'(col_reg);
    assign tab_n     = (cols_left < LEFT_W'(cfg.tab_width)) ? 4'(cols_left) : cfg.tab_width;
    assign last_col  = (col_reg == COL_W'(COLUMNS - 1));
    assign last_row  = (row_reg == ROW_W'(ROWS - 1));
    assign idx_ok    = (32'(cmd.read_index) < CELLS);
    assign fill_word = (state_reg == ST_INIT) ? RESET_CELL : {cfg.text_color, CH_SPACE};
    assign cmd_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        tab_left_next  = tab_left_reg;
        cnt_next       = cnt_reg;
        copy_wr_next   = 1'b0;
        copy_addr_next = copy_addr_reg;
        rd_ok_next     = rd_ok_reg;
        data_hold_next = data_hold_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_addr;
        ram_wdata      = fill_word;
        ram_re         = 1'b0;
        ram_raddr      = ADDR_W'(cmd.read_index);
        res_valid      = 1'b0;
        res_data       = '0;
        fin            = 1'b0;
        nl             = 1'b0;
        plain_go       = 1'b0;
        plain_more     = 1'b0;
        plain_char     = cmd.char_code;

        unique case (state_reg) inside
            ST_INIT, ST_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    if (state_reg == ST_INIT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.operation)
                        OP_PUT:
                        begin
                            unique case (cmd.char_code)
                                CH_NEWLINE:
                                begin
                                    nl = 1'b1;
                                end
                                CH_TAB:
                                begin
                                    if (tab_n == '0)
                                    begin
                                        fin = 1'b1;
                                    end
                                    else
                                    begin
                                        tab_left_next = tab_n;
                                        state_next    = ST_TAB;
                                    end
                                end
                                CH_BACKSPACE:
                                begin
                                    col_next  = bs_col;
                                    ram_we    = 1'b1;
                                    ram_waddr = bs_addr;
                                    ram_wdata = {cfg.text_color, CH_SPACE};
                                    fin       = 1'b1;
                                end
                                default:
                                begin
                                    plain_go = 1'b1;
                                end
                            endcase
                        end
                        OP_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_BLANK;
                        end
                        OP_READ:
                        begin
                            ram_re     = idx_ok;
                            rd_ok_next = idx_ok;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_TAB:
            begin
                plain_go      = 1'b1;
                plain_char    = CH_SPACE;
                plain_more    = (tab_left_reg != 4'd1);
                tab_left_next = tab_left_reg - 4'd1;
            end
            ST_READ:
            begin
                res_data = rd_ok_reg ? rd_data_reg : '0;
                fin      = 1'b1;
            end
            ST_SCROLL:
            begin
                // Stream each row one up: the read runs one cell ahead of the write.
                if (cnt_reg < ADDR_W'(COPY_N))
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = cnt_reg + ADDR_W'(COLUMNS);
                    copy_wr_next = 1'b1;
                end
                if (copy_wr_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = copy_addr_reg;
                    ram_wdata = rd_data_reg;
                end
                copy_addr_next = cnt_reg;
                if (cnt_reg == ADDR_W'(COPY_N))
                begin
                    state_next = ST_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                res_data  = data_hold_reg;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (plain_go)
        begin
            ram_we    = 1'b1;
            ram_waddr = cur_addr;
            ram_wdata = {cfg.text_color, plain_char};
            if (last_col)
            begin
                nl = 1'b1;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
                if (!plain_more)
                begin
                    fin = 1'b1;
                end
            end
        end

        if (nl)
        begin
            col_next = '0;
            if (last_row)
            begin
                cnt_next   = '0;
                state_next = ST_SCROLL;
            end
            else
            begin
                row_next = row_reg + ROW_W'(1);
                fin      = 1'b1;
            end
        end

        if (fin)
        begin
            res_valid      = 1'b1;
            data_hold_next = res_data;
            state_next     = res_ready ? ST_IDLE : ST_DONE;
        end
    end

    assign res_pos = ADDR_W'(row_next) * ADDR_W'(COLUMNS) + ADDR_W'(col_next);

    always_comb
    begin
        res.cursor_row = 5'(row_next);
        res.cursor_col = 7'(col_next);
        res.cursor_pos = 11'(res_pos);
        res.cell_data  = res_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            row_reg      <= '0;
            col_reg      <= '0;
            tab_left_reg <= '0;
            cnt_reg      <= '0;
            copy_wr_reg  <= 1'b0;
            rd_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            tab_left_reg <= tab_left_next;
            cnt_reg      <= cnt_next;
            copy_wr_reg  <= copy_wr_next;
            rd_ok_reg    <= rd_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        copy_addr_reg <= copy_addr_next;
        data_hold_reg <= data_hold_next;
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            mem[ram_waddr] <= ram_wdata;
        end
        if (ram_re)
        begin
            rd_data_reg <= mem[ram_raddr];
        end
    end

    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (32'(ram_waddr) < CELLS))
        else $error("screen write address out of range");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> ((row_reg <= ROW_W'(ROWS - 1)) && (col_reg <= COL_W'(COLUMNS - 1))))
        else $error("cursor outside the screen");

    a_scroll_lag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL && ram_we && ram_re)
            |-> (ram_raddr == ram_waddr + ADDR_W'(COLUMNS + 1)))
        else $error("scroll copy read and write out of step");

    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> (state_reg == ST_IDLE))
        else $error("sequencer not idle after delivering a result");

endmodule

`default_nettype wire

// ----- tb/text_mode_terminal_writer_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text-mode terminal writer testbench
// Drives command beats into the terminal core and checks every response beat
// against a cycle-free shadow of the screen, the cursor and the two registers.
// A short directed pass covers reset contents, field extremes and edge cases;
// random phases under several register settings follow, with random idling
// on both sides, one long response hold-off and one stretch with no idling.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer_core_tb;

    import tmtw_pkg::*;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;

    // Codes the package leaves unnamed: the spare opcode and the spare register.
    localparam logic [1:0]           OP_NONE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int IDLE_PCT      = 29;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 104;
    localparam int SETTLE_CYCLES = 50;
    // The slowest legal run scrolls on every beat and still waits out the idling
    // on both sides; the limit is several times that.
    localparam int LIMIT_CYCLES  = 8_000_000;

    // Register settings for phases 1 to 5; phase 0 keeps the reset values and
    // the last phase draws both registers at random.
    localparam logic [7:0] COLOR_PLAN [5] = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h0F};
    localparam logic [7:0] TAB_PLAN   [5] = '{8'h0F, 8'h00, 8'h01, 8'hF3, 8'h08};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_stall;
    cmd_item_t             cmd = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_item_t             rsp;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [7:0]            cfg_data = '0;

    text_mode_terminal_writer_core #(
        .COLUMNS (COLS),
        .ROWS    (ROWS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow of the terminal: screen words, cursor and the two registers.
    // ------------------------------------------------------------------------
    logic [15:0] screen_shadow [CELLS];
    int          cur_row;
    int          cur_col;
    logic [7:0]  color_shadow;
    logic [3:0]  tab_shadow;

    // Cursor reports still owed by the block, oldest first.
    rsp_item_t   pending_reports [$];

    // Run statistics and failure counters.
    int          beats_sent;
    int          reads_sent;
    int          clears_sent;
    int          scrolls_seen;
    int          tab_spaces;
    int          settings_used;
    int          beats_checked;
    int          bad_beats;
    int          cycle_count;

    // Idling control shared by the sender and the receiver. A hold-off is
    // requested by bumping hold_requests; the stall process counts it down.
    bit          idle_on = 1'b1;
    int          hold_requests;
    int          hold_served;
    int          hold_left;

    // Moves the cursor to column 0 of the next row. Running off the bottom
    // shifts every row up by one and fills the last row with blanks.
    task automatic advance_line();
        int i;
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS)
        begin
            cur_row = ROWS - 1;
            scrolls_seen++;
            for (i = 0; i < CELLS - COLS; i++)
                screen_shadow[i] = screen_shadow[i + COLS];
            for (i = CELLS - COLS; i < CELLS; i++)
                screen_shadow[i] = {color_shadow, CH_SPACE};
        end
    endtask

    // Writes one glyph at the cursor and steps right, wrapping at the row end.
    task automatic place_glyph(input logic [7:0] glyph);
        screen_shadow[cur_row * COLS + cur_col] = {color_shadow, glyph};
        cur_col++;
        if (cur_col >= COLS)
            advance_line();
    endtask

    // Applies one command beat to the shadow and forms the cursor report
    // that the block must return for it.
    task automatic terminal_step(input cmd_item_t c, output rsp_item_t report);
        int spaces;
        int i;
        report = '0;
        case (c.operation)
            OP_PUT:
            begin
                if (c.char_code == CH_NEWLINE)
                    advance_line();
                else if (c.char_code == CH_TAB)
                begin
                    // A tab never writes past the end of the current row, but its
                    // last space may still wrap the cursor onto the next one.
                    spaces = COLS - cur_col;
                    if (spaces > int'(tab_shadow))
                        spaces = int'(tab_shadow);
                    tab_spaces += spaces;
                    for (i = 0; i < spaces; i++)
                        place_glyph(CH_SPACE);
                end
                else if (c.char_code == CH_BACKSPACE)
                begin
                    if (cur_col > 0)
                        cur_col--;
                    screen_shadow[cur_row * COLS + cur_col] = {color_shadow, CH_SPACE};
                end
                else
                    place_glyph(c.char_code);
            end
            OP_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    screen_shadow[i] = {color_shadow, CH_SPACE};
                cur_row = 0;
                cur_col = 0;
            end
            OP_READ:
            begin
                if (int'(c.read_index) < CELLS)
                    report.cell_data = screen_shadow[c.read_index];
            end
            default:
            begin
            end
        endcase
        report.cursor_row = 5'(cur_row);
        report.cursor_col = 7'(cur_col);
        report.cursor_pos = 11'(cur_row * COLS + cur_col);
    endtask

    // ------------------------------------------------------------------------
    // Sender side. A beat is presented at a falling edge, after a random number
    // of idle cycles, and is taken at the first rising edge without a stall.
    // The shadow is advanced at that edge, so its order matches the block's.
    // ------------------------------------------------------------------------
    task automatic send_command(input cmd_item_t c, input bit typed, input rsp_item_t want);
        rsp_item_t predicted;
        @(negedge clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        terminal_step(c, predicted);
        // Rows with a hand-written report are checked against that report;
        // the shadow still runs so that later rows stay in step.
        pending_reports.push_back(typed ? want : predicted);
        beats_sent++;
        if (c.operation == OP_READ)
            reads_sent++;
        if (c.operation == OP_CLEAR)
            clears_sent++;
    endtask

    // Lowers valid and waits until every owed report has come back, so the
    // block is idle afterwards.
    task automatic drain_reports();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // One register write on the configuration channel; the shadow takes the
    // new value at the edge where the write lands.
    task automatic program_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_TEXT_COLOR)
            color_shadow = value;
        else if (idx == CFG_TAB_WIDTH)
            tab_shadow = value[3:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random command: mostly printable text, with control characters, reads
    // near and far from the cursor and past the screen, the odd clear and the spare opcode.
    // Fields that the operation ignores still carry random bits.
    function automatic cmd_item_t random_command();
        cmd_item_t c;
        int        pick;
        c.operation  = OP_PUT;
        c.char_code  = 8'($urandom_range(255));
        c.read_index = 11'($urandom_range(2047));
        pick = $urandom_range(99);
        if (pick < 5)
            c.char_code = CH_NEWLINE;
        else if (pick < 12)
            c.char_code = CH_TAB;
        else if (pick < 19)
            c.char_code = CH_BACKSPACE;
        else if (pick < 26)
        begin
            // Read back a cell of the row being written.
            c.operation  = OP_READ;
            c.read_index = 11'(cur_row * COLS + $urandom_range(COLS - 1));
        end
        else if (pick < 32)
        begin
            c.operation  = OP_READ;
            c.read_index = 11'($urandom_range(CELLS - 1));
        end
        else if (pick < 34)
            c.operation = OP_READ;
        else if (pick < 35)
            c.operation = OP_CLEAR;
        else if (pick < 36)
            c.operation = OP_NONE;
        return c;
    endfunction

    // Random traffic. Now and then a run of newlines pushes the cursor to the
    // bottom so that scrolling, wrapping and tabs near the row end all occur.
    // Beats that the block ignores are not counted.
    task automatic run_random(input int count);
        int        sent;
        int        burst;
        cmd_item_t c;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 3)
            begin
                burst = $urandom_range(12, 4);
                repeat (burst)
                begin
                    c = random_command();
                    c.operation = OP_PUT;
                    c.char_code = CH_NEWLINE;
                    send_command(c, 1'b0, '0);
                end
                sent += burst;
            end
            else
            begin
                c = random_command();
                send_command(c, 1'b0, '0);
                if (c.operation != OP_NONE)
                    sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver side. Stall is chosen at each falling edge: held high during a
    // requested hold-off, random while idling is on, low otherwise.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end

    // Every response beat taken is compared field by field with the oldest
    // owed report. A beat with nothing owed is a failure too.
    always @(posedge clk)
    begin : check_reports
        rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("%0t: response beat with nothing outstanding: row %0d col %0d pos %0d data %h",
                             $time, rsp.cursor_row, rsp.cursor_col, rsp.cursor_pos, rsp.cell_data);
            end
            else
            begin
                want = pending_reports.pop_front();
                beats_checked++;
                if (rsp.cursor_row !== want.cursor_row || rsp.cursor_col !== want.cursor_col ||
                    rsp.cursor_pos !== want.cursor_pos || rsp.cell_data !== want.cell_data)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("%0t: mismatch: expected row %0d col %0d pos %0d data %h, got row %0d col %0d pos %0d data %h",
                                 $time, want.cursor_row, want.cursor_col, want.cursor_pos,
                                 want.cell_data, rsp.cursor_row, rsp.cursor_col,
                                 rsp.cursor_pos, rsp.cell_data);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles with %0d reports outstanding",
                     cycle_count, pending_reports.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed plan: one row per beat, with the report typed in where it is
    // obvious from the reset state and the beats before it.
    // ------------------------------------------------------------------------
    typedef struct {
        cmd_item_t c;
        bit        typed;
        rsp_item_t want;
    } plan_row_t;

    plan_row_t directed_plan [$];

    task automatic plan(input logic [1:0] op, input logic [7:0] ch, input logic [10:0] idx,
                        input bit typed, input int row, input int col, input logic [15:0] data);
        plan_row_t r;
        r.c.operation       = op;
        r.c.char_code       = ch;
        r.c.read_index      = idx;
        r.typed             = typed;
        r.want.cursor_row   = 5'(row);
        r.want.cursor_col   = 7'(col);
        r.want.cursor_pos   = 11'(row * COLS + col);
        r.want.cell_data    = data;
        directed_plan.push_back(r);
    endtask

    initial
    begin : stimulus
        int        i;
        int        p;
        cmd_item_t c;

        for (i = 0; i < CELLS; i++)
            screen_shadow[i] = RESET_CELL;
        cur_row      = 0;
        cur_col      = 0;
        color_shadow = RESET_COLOR;
        tab_shadow   = RESET_TAB;

        // Reset contents, including both ends of the screen and reads past it.
        plan(OP_READ,  8'h00,        11'd0,    1'b1, 0, 0, RESET_CELL);
        plan(OP_READ,  8'h00,        11'd1999, 1'b1, 0, 0, RESET_CELL);
        plan(OP_READ,  8'h00,        11'd2000, 1'b1, 0, 0, 16'h0000);
        plan(OP_READ,  8'hFF,        11'h7FF,  1'b1, 0, 0, 16'h0000);
        // Character codes at both extremes, written in the reset color.
        plan(OP_PUT,   8'h41,        11'h7FF,  1'b1, 0, 1, 16'h0000);
        plan(OP_PUT,   8'hFF,        11'd0,    1'b1, 0, 2, 16'h0000);
        plan(OP_PUT,   8'h00,        11'd0,    1'b1, 0, 3, 16'h0000);
        plan(OP_READ,  8'h00,        11'd0,    1'b1, 0, 3, 16'h0741);
        plan(OP_READ,  8'h00,        11'd1,    1'b1, 0, 3, 16'h07FF);
        // Backspace steps left and blanks the cell it lands on.
        plan(OP_PUT,   CH_BACKSPACE, 11'd0,    1'b1, 0, 2, 16'h0000);
        plan(OP_READ,  8'h00,        11'd2,    1'b1, 0, 2, RESET_CELL);
        plan(OP_PUT,   CH_TAB,       11'd0,    1'b0, 0, 0, 16'h0000);
        plan(OP_PUT,   CH_NEWLINE,   11'd0,    1'b1, 1, 0, 16'h0000);
        // Backspace at column 0 stays there.
        plan(OP_PUT,   CH_BACKSPACE, 11'd0,    1'b1, 1, 0, 16'h0000);
        // The spare opcode leaves everything alone.
        plan(OP_NONE,  8'hFF,        11'h7FF,  1'b1, 1, 0, 16'h0000);
        plan(OP_PUT,   CH_TAB,       11'd0,    1'b0, 0, 0, 16'h0000);
        plan(OP_PUT,   8'h80,        11'h400,  1'b0, 0, 0, 16'h0000);
        plan(OP_READ,  8'h00,        11'd84,   1'b0, 0, 0, 16'h0000);
        plan(OP_READ,  8'h55,        11'h555,  1'b0, 0, 0, 16'h0000);
        plan(OP_READ,  8'hAA,        11'h2AA,  1'b0, 0, 0, 16'h0000);
        plan(OP_CLEAR, 8'hFF,        11'h7FF,  1'b1, 0, 0, 16'h0000);
        plan(OP_READ,  8'h00,        11'd80,   1'b1, 0, 0, RESET_CELL);
        plan(OP_READ,  8'h00,        11'd1024, 1'b1, 0, 0, RESET_CELL);

        // Reset is held low from the start and released between edges. The block
        // then clears its screen, stalling command beats until that is done.
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[k])
            send_command(directed_plan[k].c, directed_plan[k].typed, directed_plan[k].want);

        for (p = 0; p < PHASES; p++)
        begin
            // Registers change only while the block has nothing in flight.
            drain_reports();
            if (p == 1)
                program_register(CFG_SPARE, 8'($urandom_range(255)));
            if (p > 0 && p <= 5)
            begin
                program_register(CFG_TEXT_COLOR, COLOR_PLAN[p - 1]);
                program_register(CFG_TAB_WIDTH, TAB_PLAN[p - 1]);
            end
            else if (p > 5)
            begin
                program_register(CFG_TEXT_COLOR, 8'($urandom_range(255)));
                program_register(CFG_TAB_WIDTH, 8'($urandom_range(255)));
            end
            settings_used++;

            // One phase runs with both sides always ready.
            idle_on = (p != 2);

            if (p == 4)
            begin
                // The receiver holds off for a long stretch while the sender keeps
                // offering text back to back, so the block backs up into its input.
                idle_on = 1'b0;
                hold_requests++;
                for (i = 0; i < 24; i++)
                begin
                    c = random_command();
                    c.operation = OP_PUT;
                    c.char_code = 8'h61 + 8'(i);
                    send_command(c, 1'b0, '0);
                end
                idle_on = 1'b1;
            end

            run_random(PHASE_ITEMS);
        end

        drain_reports();
        // Keep the clock running to catch any beat the block should not send.
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Covered %0d command beats under %0d register settings: %0d reads, %0d clears, %0d scrolls, %0d tab spaces.",
                 beats_sent, settings_used, reads_sent, clears_sent, scrolls_seen, tab_spaces);
        $display("Checked %0d response beats in %0d cycles, %0d failing.",
                 beats_checked, cycle_count, bad_beats);
        if (bad_beats == 0 && pending_reports.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tmtw_pkg.sv
rtl/tmtw_engine.sv
rtl/text_mode_terminal_writer_core.sv
tb/text_mode_terminal_writer_core_tb.sv
